/* sv/tfpt_pkg.sv */
// Package for the page translate block: widths, command and status codes,
// and the structs passed between the TLB, the page table and the top level.
// No dependencies.
package tfpt_pkg;

   localparam int TLB_ENTRIES = 4;
   localparam int PAGE_COUNT  = 16;
   localparam int TLB_IDX_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

   localparam int ADDR_W    = 16;
   localparam int PAGE_W    = 4;
   localparam int FRAME_W   = 4;
   localparam int OFFSET_W  = 12;
   localparam int PROTECT_W = 8;
   localparam int COUNT_W   = 32;

   typedef enum logic {
      CMD_TRANSLATE = 1'b0,
      CMD_WRITE     = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_SEGV       = 2'd1,
      ST_TLB_PROT   = 2'd2,
      ST_TABLE_PROT = 2'd3
   } status_type;

   typedef struct packed {
      logic                 hit;
      logic [FRAME_W-1:0]   frame;
      logic [PROTECT_W-1:0] protect;
   } tlb_lookup_type;

   typedef struct packed {
      logic                 en;
      logic [PAGE_W-1:0]    page;
      logic [FRAME_W-1:0]   frame;
      logic [PROTECT_W-1:0] protect;
   } tlb_fill_type;

   typedef struct packed {
      logic                 valid;
      logic [FRAME_W-1:0]   frame;
      logic [PROTECT_W-1:0] protect;
   } pte_type;

   typedef struct packed {
      logic                 en;
      logic [PAGE_W-1:0]    page;
      pte_type              pte;
   } pte_write_type;

endpackage

/* sv/tfpt_table.sv */
// Page table: PAGE_COUNT entries in flops, identity mapping at reset.
// One write port, one combinational read port. Depends on tfpt_pkg.
module tfpt_table (
   input  logic                        clock,
   input  logic                        reset,
   input  tfpt_pkg::pte_write_type     wr,
   input  logic [tfpt_pkg::PAGE_W-1:0] rd_page,
   output tfpt_pkg::pte_type           rd_pte
);
   import tfpt_pkg::*;

   logic [FRAME_W-1:0]   frame_ff   [PAGE_COUNT];
   logic                 valid_ff   [PAGE_COUNT];
   logic [PROTECT_W-1:0] protect_ff [PAGE_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAGE_COUNT; i++) begin
            frame_ff[i]   <= FRAME_W'(i);
            valid_ff[i]   <= 1'b1;
            protect_ff[i] <= '1;
         end
      end else if (wr.en) begin
         frame_ff[wr.page]   <= wr.pte.frame;
         valid_ff[wr.page]   <= wr.pte.valid;
         protect_ff[wr.page] <= wr.pte.protect;
      end
   end

   always_comb begin
      rd_pte.valid   = valid_ff[rd_page];
      rd_pte.frame   = frame_ff[rd_page];
      rd_pte.protect = protect_ff[rd_page];
   end

endmodule

/* sv/tfpt_tlb.sv */
// Fully associative TLB: parallel compare over all slots, lowest valid match
// wins; fills go to the slot named by a round-robin pointer. Depends on tfpt_pkg.
module tfpt_tlb (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tfpt_pkg::PAGE_W-1:0] lookup_page,
   output tfpt_pkg::tlb_lookup_type    lookup,
   input  tfpt_pkg::tlb_fill_type      fill
);
   import tfpt_pkg::*;

   logic [PAGE_W-1:0]    page_ff    [TLB_ENTRIES];
   logic [FRAME_W-1:0]   frame_ff   [TLB_ENTRIES];
   logic [PROTECT_W-1:0] protect_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] valid_ff;
   logic [TLB_IDX_W-1:0] ptr_ff;
   logic [TLB_IDX_W-1:0] ptr_in;

   always_comb begin
      lookup = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && page_ff[i] == lookup_page) begin
            lookup.hit     = 1'b1;
            lookup.frame   = frame_ff[i];
            lookup.protect = protect_ff[i];
         end
      end
   end

   always_comb begin
      if (ptr_ff == TLB_IDX_W'(TLB_ENTRIES - 1)) begin
         ptr_in = '0;
      end else begin
         ptr_in = ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
      end else if (fill.en) begin
         valid_ff[ptr_ff] <= 1'b1;
         ptr_ff           <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fill.en) begin
         page_ff[ptr_ff]    <= fill.page;
         frame_ff[ptr_ff]   <= fill.frame;
         protect_ff[ptr_ff] <= fill.protect;
      end
   end

endmodule

/* sv/tlb_fifo_page_translate.sv */
// Top level of the page translate block: input register, translate logic,
// result register, hit and miss counters. Depends on tfpt_pkg, tfpt_tlb,
// tfpt_table.
//
// Usage:
//   The req_ channel carries one command item: translate (req_cmd = 0) a
//   16-bit logical address, or write (req_cmd = 1) one page table entry.
//   The rsp_ channel returns exactly one item per command: physical address,
//   TLB hit flag, status code and the running hit and miss totals.
//   An accepted item passes through the input register and then the result
//   register, which drives rsp_valid; one item is accepted every cycle while
//   req_stall is low, with the TLB compare and fill between the two registers.
//   An item sees all table and TLB updates made by the items before it.
//   Reset clears the TLB, the FIFO pointer and both counters, and loads the
//   page table with the identity mapping, valid, full access.
//   While rsp_stall holds a waiting result, it stays unchanged; one more
//   item is taken into the input register and then req_stall rises.
module tlb_fifo_page_translate (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [tfpt_pkg::ADDR_W-1:0]    req_logical_addr,
   input  logic [tfpt_pkg::PAGE_W-1:0]    req_entry_page,
   input  logic [tfpt_pkg::FRAME_W-1:0]   req_entry_frame,
   input  logic                           req_entry_valid,
   input  logic [tfpt_pkg::PROTECT_W-1:0] req_entry_protect,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tfpt_pkg::ADDR_W-1:0]    rsp_phys_addr,
   output logic                           rsp_hit,
   output logic [1:0]                     rsp_status,
   output logic [tfpt_pkg::COUNT_W-1:0]   rsp_hits_total,
   output logic [tfpt_pkg::COUNT_W-1:0]   rsp_misses_total
);
   import tfpt_pkg::*;

   logic                 s1_valid_ff;
   cmd_type              s1_cmd_ff;
   logic [ADDR_W-1:0]    s1_addr_ff;
   logic [PAGE_W-1:0]    s1_page_ff;
   logic [FRAME_W-1:0]   s1_frame_ff;
   logic                 s1_entry_valid_ff;
   logic [PROTECT_W-1:0] s1_protect_ff;

   logic                 out_valid_ff;
   logic [ADDR_W-1:0]    out_phys_ff;
   logic                 out_hit_ff;
   status_type           out_status_ff;
   logic [COUNT_W-1:0]   hit_count_ff;
   logic [COUNT_W-1:0]   miss_count_ff;

   logic                 advance;
   logic                 commit;
   logic [PAGE_W-1:0]    vpage;
   logic [OFFSET_W-1:0]  offset;
   tlb_lookup_type       lookup;
   tlb_fill_type         fill;
   pte_type              pte;
   pte_write_type        pte_wr;
   logic [ADDR_W-1:0]    phys_in;
   logic                 hit_in;
   status_type           status_in;
   logic [COUNT_W-1:0]   hit_count_in;
   logic [COUNT_W-1:0]   miss_count_in;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign commit    = advance && s1_valid_ff;
   assign req_stall = s1_valid_ff && !advance;

   assign vpage  = s1_addr_ff[ADDR_W-1:OFFSET_W];
   assign offset = s1_addr_ff[OFFSET_W-1:0];

   tfpt_tlb u_tlb (
      .clock       (clock),
      .reset       (reset),
      .lookup_page (vpage),
      .lookup      (lookup),
      .fill        (fill)
   );

   tfpt_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (pte_wr),
      .rd_page (vpage),
      .rd_pte  (pte)
   );

   always_comb begin
      pte_wr.en          = commit && s1_cmd_ff == CMD_WRITE;
      pte_wr.page        = s1_page_ff;
      pte_wr.pte.valid   = s1_entry_valid_ff;
      pte_wr.pte.frame   = s1_frame_ff;
      pte_wr.pte.protect = s1_protect_ff;
   end

   always_comb begin
      phys_in       = '0;
      hit_in        = 1'b0;
      status_in     = ST_OK;
      hit_count_in  = hit_count_ff;
      miss_count_in = miss_count_ff;
      fill.en       = 1'b0;
      fill.page     = vpage;
      fill.frame    = pte.frame;
      fill.protect  = pte.protect;
      if (s1_cmd_ff == CMD_TRANSLATE) begin
         if (lookup.hit) begin
            hit_in       = 1'b1;
            hit_count_in = hit_count_ff + 1'b1;
            if (lookup.protect == '0) begin
               status_in = ST_TLB_PROT;
            end else begin
               phys_in = {lookup.frame, offset};
            end
         end else begin
            miss_count_in = miss_count_ff + 1'b1;
            if (!pte.valid) begin
               status_in = ST_SEGV;
            end else if (pte.protect == '0) begin
               status_in = ST_TABLE_PROT;
            end else begin
               fill.en = commit;
               phys_in = {pte.frame, offset};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         s1_cmd_ff         <= cmd_type'(req_cmd);
         s1_addr_ff        <= req_logical_addr;
         s1_page_ff        <= req_entry_page;
         s1_frame_ff       <= req_entry_frame;
         s1_entry_valid_ff <= req_entry_valid;
         s1_protect_ff     <= req_entry_protect;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hit_count_ff  <= '0;
         miss_count_ff <= '0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            hit_count_ff  <= hit_count_in;
            miss_count_ff <= miss_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         out_phys_ff   <= phys_in;
         out_hit_ff    <= hit_in;
         out_status_ff <= status_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_phys_addr    = out_phys_ff;
   assign rsp_hit          = out_hit_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_hits_total   = hit_count_ff;
   assign rsp_misses_total = miss_count_ff;

endmodule
